// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define OBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define OBM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/obm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obm_pkg
// Types, codes and bus timing constants of the 1-wire bus master.
// ----------------------------------------------------------------------------
package obm_pkg;

  localparam int OBM_QDEPTH = 4;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_RESET = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic [9:0] T_RST_LOW   = 10'd600;
  localparam logic [9:0] T_RST_RELAX = 10'd80;
  localparam logic [9:0] T_RST_WAIT  = 10'd520;
  localparam logic [9:0] T_W1_LOW    = 10'd2;
  localparam logic [9:0] T_W0_LOW    = 10'd60;
  localparam logic [9:0] T_WSLOT     = 10'd65;
  localparam logic [9:0] T_R_LOW     = 10'd3;
  localparam logic [9:0] T_R_SAMPLE  = 10'd11;
  localparam logic [9:0] T_RSLOT     = 10'd56;

  localparam logic [2:0] RST_STEP_LOW  = 3'd0;
  localparam logic [2:0] RST_STEP_WAIT = 3'd2;
  localparam logic [2:0] LAST_BIT      = 3'd7;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_RESET,
    CMD_WRITE,
    CMD_READ
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RESET,
    PH_WRITE,
    PH_READ
  } phase_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       pin_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_byte;
    logic       rejected;
  } result_t;

  function automatic phase_t cmd_phase(input cmd_t cmd);
    phase_t ph;
    case (cmd)
      CMD_RESET: ph = PH_RESET;
      CMD_WRITE: ph = PH_WRITE;
      CMD_READ:  ph = PH_READ;
      default:   ph = PH_IDLE;
    endcase
    return ph;
  endfunction

endpackage

// ===== hdl/obm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obm_in_if / obm_out_if
// Valid/ready channels for tick beats in and result beats out.
// ----------------------------------------------------------------------------
interface obm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] tx_byte;
  logic       pin_level;

  modport source (output valid, mode, tx_byte, pin_level, input ready);
  modport sink   (input valid, mode, tx_byte, pin_level, output ready);
endinterface

interface obm_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] rx_byte;
  logic       rejected;

  modport source (output valid, drive_low, busy_res, done_res, presence, rx_byte, rejected,
                  input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, presence, rx_byte, rejected,
                  output ready);
endinterface

// ===== hdl/obm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obm_front
// Accepts tick beats, decodes the command and queues them for the engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module obm_front #(
  parameter int QDEPTH = obm_pkg::OBM_QDEPTH
) (
  input  logic          clk,
  input  logic          rst,
  obm_in_if.sink        in_ch,
  output logic          q_valid,
  output obm_pkg::item_t q_item,
  input  logic          q_ready
);
  import obm_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QDEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QDEPTH);

  item_t            slots [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  item_t            dec_item;
  logic             push;
  logic             pop;

  always_comb begin
    case (in_ch.mode)
      MODE_RESET: dec_item.cmd = CMD_RESET;
      MODE_WRITE: dec_item.cmd = CMD_WRITE;
      MODE_READ:  dec_item.cmd = CMD_READ;
      default:    dec_item.cmd = CMD_NONE;
    endcase
    dec_item.tx_byte   = in_ch.tx_byte;
    dec_item.pin_level = in_ch.pin_level;
  end

  assign in_ch.ready = (count != FULL_CNT);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count != '0);
  assign pop         = q_valid && q_ready;
  assign q_item      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= dec_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  `OBM_ASSERT(a_count_track, !$past(rst) |-> (count == $past(count) + CNT_W'($past(push)) - CNT_W'($past(pop))), "queue count out of step with beats")
  `OBM_ASSERT(a_count_bound, count <= FULL_CNT, "queue count beyond depth")

endmodule

// ===== hdl/obm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obm_back
// Bus timing engine: runs reset, write and read slots one tick per beat and
// holds each result in an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module obm_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  obm_pkg::item_t q_item,
  output logic           q_ready,
  obm_out_if.source      out_ch
);
  import obm_pkg::*;

  phase_t     phase, phase_next;
  logic [2:0] bit_index, bit_index_next;
  logic [9:0] usec_count, usec_count_next;
  logic [7:0] shift_data, shift_data_next;
  logic       presence_flag, presence_flag_next;
  logic [7:0] rx_last, rx_last_next;
  logic [9:0] slot_len;
  logic [9:0] usec_inc;
  logic [9:0] low_len;
  result_t    res, res_next;
  logic       out_valid;
  logic       fire;

  assign q_ready = !out_valid || out_ch.ready;
  assign fire    = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_index     <= '0;
      usec_count    <= '0;
      shift_data    <= '0;
      presence_flag <= 1'b0;
      rx_last       <= '0;
    end else begin
      phase         <= phase_next;
      bit_index     <= bit_index_next;
      usec_count    <= usec_count_next;
      shift_data    <= shift_data_next;
      presence_flag <= presence_flag_next;
      rx_last       <= rx_last_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    bit_index_next     = bit_index;
    usec_count_next    = usec_count;
    shift_data_next    = shift_data;
    presence_flag_next = presence_flag;
    rx_last_next       = rx_last;
    res_next           = '0;
    slot_len           = T_RSLOT;
    usec_inc           = usec_count + 10'd1;
    low_len            = T_W0_LOW;
    if (fire) begin
      if (phase == PH_IDLE) begin
        if (q_item.cmd != CMD_NONE) begin
          phase_next      = cmd_phase(q_item.cmd);
          bit_index_next  = '0;
          usec_count_next = '0;
          shift_data_next = (q_item.cmd == CMD_WRITE) ? q_item.tx_byte : 8'd0;
        end
      end else if (q_item.cmd != CMD_NONE) begin
        res_next.rejected = 1'b1;
      end
      usec_inc = usec_count_next + 10'd1;
      case (phase_next)
        PH_RESET: begin
          res_next.busy_res  = 1'b1;
          res_next.drive_low = (bit_index_next == RST_STEP_LOW);
          if (bit_index_next >= RST_STEP_WAIT && usec_count_next == '0) begin
            presence_flag_next = !q_item.pin_level;
          end
          if (bit_index_next == RST_STEP_LOW) begin
            slot_len = T_RST_LOW;
          end else if (bit_index_next < RST_STEP_WAIT) begin
            slot_len = T_RST_RELAX;
          end else begin
            slot_len = T_RST_WAIT;
          end
          usec_count_next = usec_inc;
          if (usec_inc >= slot_len) begin
            usec_count_next = '0;
            if (bit_index_next >= RST_STEP_WAIT) begin
              res_next.done_res = 1'b1;
              phase_next        = PH_IDLE;
              bit_index_next    = '0;
            end else begin
              bit_index_next = bit_index_next + 3'd1;
            end
          end
        end
        PH_WRITE: begin
          res_next.busy_res  = 1'b1;
          low_len            = shift_data_next[bit_index_next] ? T_W1_LOW : T_W0_LOW;
          res_next.drive_low = (usec_count_next < low_len);
          usec_count_next    = usec_inc;
          if (usec_inc >= T_WSLOT) begin
            usec_count_next = '0;
            if (bit_index_next >= LAST_BIT) begin
              res_next.done_res = 1'b1;
              phase_next        = PH_IDLE;
              bit_index_next    = '0;
            end else begin
              bit_index_next = bit_index_next + 3'd1;
            end
          end
        end
        PH_READ: begin
          res_next.busy_res  = 1'b1;
          res_next.drive_low = (usec_count_next < T_R_LOW);
          if (usec_count_next == T_R_SAMPLE && q_item.pin_level) begin
            shift_data_next[bit_index_next] = 1'b1;
          end
          usec_count_next = usec_inc;
          if (usec_inc >= T_RSLOT) begin
            usec_count_next = '0;
            if (bit_index_next >= LAST_BIT) begin
              res_next.done_res = 1'b1;
              phase_next        = PH_IDLE;
              bit_index_next    = '0;
              rx_last_next      = shift_data_next;
            end else begin
              bit_index_next = bit_index_next + 3'd1;
            end
          end
        end
        default: begin
        end
      endcase
      res_next.presence = presence_flag_next;
      res_next.rx_byte  = rx_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.drive_low = res.drive_low;
  assign out_ch.busy_res  = res.busy_res;
  assign out_ch.done_res  = res.done_res;
  assign out_ch.presence  = res.presence;
  assign out_ch.rx_byte   = res.rx_byte;
  assign out_ch.rejected  = res.rejected;

  `OBM_ASSERT(a_done_busy, (out_valid && res.done_res) |-> res.busy_res, "done beat not marked busy")
  `OBM_ASSERT(a_rej_busy, (out_valid && res.rejected) |-> res.busy_res, "rejected beat not marked busy")
  `OBM_ASSERT(a_hold_state, !fire |=> ($stable(phase) && $stable(usec_count)), "engine moved without a beat")
  `OBM_ASSERT(a_done_idle, (fire && res_next.done_res) |=> (phase == PH_IDLE), "engine not idle after done")

endmodule

// ===== hdl/onewire_bus_master_unit.sv =====
`timescale 1ns / 1ps
// An accepted tick beat is registered first in the queue, then its result in the
// output register, from which the result beat is valid.
// Throughput: one tick beat per cycle, retired by the engine, unless the output stalls.
// The decode queue (QDEPTH entries) absorbs output stalls; input ready drops when full.
// Reset: synchronous; engine returns to idle, presence and last read byte clear,
// queue and output register empty.
// ----------------------------------------------------------------------------
// onewire_bus_master_unit
// 1-wire bus master timed in microsecond tick beats: reset/presence, write
// byte and read byte.
// ----------------------------------------------------------------------------
module onewire_bus_master_unit #(
  parameter int QDEPTH = obm_pkg::OBM_QDEPTH
) (
  input  logic      clk,
  input  logic      rst,
  obm_in_if.sink    in_ch,
  obm_out_if.source out_ch
);
  import obm_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  obm_front #(
    .QDEPTH(QDEPTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_valid(q_valid),
    .q_item (q_item),
    .q_ready(q_ready)
  );

  obm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_item (q_item),
    .q_ready(q_ready),
    .out_ch (out_ch)
  );

endmodule
